// ===== sv/crc16fr_pkg.sv =====
// Package for the CRC-16 frame receiver: widths, frame constants, event codes
// and the byte-wide CRC-16 update. No dependencies.
package crc16fr_pkg;

  localparam int unsigned FRAME_BUF_BYTES = 1024;
  localparam int unsigned CNT_W       = $clog2(FRAME_BUF_BYTES) + 1;
  localparam int unsigned DELAY_LEN   = 6;
  localparam int unsigned BLEN_W      = 11;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned OUT_USER_W  = 3;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_MSB   = 16'h8000;
  localparam logic [7:0]  HEAD_BYTE = 8'hBE;
  localparam logic [7:0]  END_BYTE  = 8'hED;

  typedef enum logic [1:0] {
    EV_CONTINUE  = 2'd0,
    EV_FRAME_OK  = 2'd1,
    EV_CRC_ERROR = 2'd2,
    EV_DROP      = 2'd3
  } event_e;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc16_frame_receiver_core.sv =====
// A result is registered and appears on the master side in the cycle after its byte
// is accepted. Throughput: one byte per cycle while the master side takes results; one
// request in, one result out, with the CRC and delay-line update done combinationally.
// Reset: asynchronous, active low; returns to hunt mode with count, delay line,
// CRC, command and length cleared and no result pending.
// Byte-serial deframer: header hunt, six-byte delay line, CRC-16 check.
// Depends on crc16fr_pkg.
module crc16_frame_receiver_core
  import crc16fr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] rx_byte
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] payload_byte, [23:8] command, [39:24] declared_length,
  // [50:40] body_length, [55:51] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_USER_W-1:0] m_axis_tuser_o     // [1:0] event_res, [2] payload_valid
);

  logic             in_body_q, in_body_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [7:0]       line_q [DELAY_LEN];
  logic [7:0]       line_d [DELAY_LEN];
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;

  logic              out_valid_q;
  event_e            ev_q, ev_d;
  logic              pv_q, pv_d;
  logic [7:0]        pb_q, pb_d;
  logic [15:0]       ocmd_q, ocmd_d;
  logic [15:0]       olen_q, olen_d;
  logic [BLEN_W-1:0] blen_q, blen_d;

  logic       s_acc;
  logic [7:0] b;
  logic       four_head, four_end, clear_line;
  logic [15:0] crc_got;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign cnt_new         = cnt_q + CNT_W'(1);
  assign four_head = (line_q[3] == HEAD_BYTE) && (line_q[4] == HEAD_BYTE) &&
                     (line_q[5] == HEAD_BYTE) && (b == HEAD_BYTE);
  assign four_end  = (line_q[3] == END_BYTE) && (line_q[4] == END_BYTE) &&
                     (line_q[5] == END_BYTE) && (b == END_BYTE);
  assign crc_got   = {line_q[1], line_q[2]};

  always_comb begin
    in_body_d  = in_body_q;
    cnt_d      = cnt_new;
    crc_d      = crc_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    clear_line = 1'b0;
    ev_d       = EV_CONTINUE;
    pv_d       = 1'b0;
    pb_d       = 8'h00;
    ocmd_d     = 16'h0000;
    olen_d     = 16'h0000;
    blen_d     = '0;
    for (int i = 0; i < DELAY_LEN - 1; i++) begin
      line_d[i] = line_q[i+1];
    end
    line_d[DELAY_LEN-1] = b;

    if (!in_body_q) begin
      if (cnt_new >= CNT_W'(4) && four_head) begin
        clear_line = 1'b1;
        crc_d      = 16'h0000;
        cmd_d      = 16'h0000;
        len_d      = 16'h0000;
        in_body_d  = 1'b1;
      end else if (cnt_new >= CNT_W'(4) && four_end) begin
        clear_line = 1'b1;
      end else if (cnt_new >= CNT_W'(FRAME_BUF_BYTES)) begin
        clear_line = 1'b1;
        ev_d       = EV_DROP;
      end
    end else begin
      if (cnt_q == CNT_W'(0)) begin
        len_d = {b, len_q[7:0]};
      end else if (cnt_q == CNT_W'(1)) begin
        len_d = {len_q[15:8], b};
      end else if (cnt_q == CNT_W'(2)) begin
        cmd_d = {b, cmd_q[7:0]};
      end else if (cnt_q == CNT_W'(3)) begin
        cmd_d = {cmd_q[15:8], b};
      end
      if (cnt_new >= CNT_W'(DELAY_LEN + 1)) begin
        crc_d = crc_feed(crc_q, line_q[0]);
        if (cnt_new >= CNT_W'(DELAY_LEN + 5)) begin
          pv_d = 1'b1;
          pb_d = line_q[0];
        end
      end
      if (cnt_new >= CNT_W'(DELAY_LEN) && four_end) begin
        ev_d       = (crc_got == crc_d) ? EV_FRAME_OK : EV_CRC_ERROR;
        ocmd_d     = cmd_d;
        olen_d     = len_d;
        blen_d     = BLEN_W'(cnt_new);
        clear_line = 1'b1;
        in_body_d  = 1'b0;
      end else if (cnt_new >= CNT_W'(FRAME_BUF_BYTES)) begin
        clear_line = 1'b1;
        in_body_d  = 1'b0;
        ev_d       = EV_DROP;
      end
    end

    if (clear_line) begin
      cnt_d = '0;
      for (int i = 0; i < DELAY_LEN; i++) begin
        line_d[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q   <= 1'b0;
      cnt_q       <= '0;
      crc_q       <= 16'h0000;
      cmd_q       <= 16'h0000;
      len_q       <= 16'h0000;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DELAY_LEN; i++) begin
        line_q[i] <= 8'h00;
      end
    end else begin
      if (s_acc) begin
        in_body_q <= in_body_d;
        cnt_q     <= cnt_d;
        crc_q     <= crc_d;
        cmd_q     <= cmd_d;
        len_q     <= len_d;
        for (int i = 0; i < DELAY_LEN; i++) begin
          line_q[i] <= line_d[i];
        end
      end
      if (s_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ev_q   <= ev_d;
      pv_q   <= pv_d;
      pb_q   <= pb_d;
      ocmd_q <= ocmd_d;
      olen_q <= olen_d;
      blen_q <= blen_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {pv_q, ev_q};
  assign m_axis_tdata_o  = {(OUT_DATA_W - BLEN_W - 40)'(0), blen_q, olen_q, ocmd_q, pb_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(FRAME_BUF_BYTES))
    else $error("byte count reached frame limit");

  a_header_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !in_body_q && cnt_new >= CNT_W'(4) && four_head
    |=> in_body_q && cnt_q == CNT_W'(0) && crc_q == 16'h0000)
    else $error("header did not start a clean body");

  a_event_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && ev_d != EV_CONTINUE |=> !in_body_q && cnt_q == CNT_W'(0))
    else $error("frame end or drop did not return to hunt");

  a_end_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (ev_q == EV_FRAME_OK || ev_q == EV_CRC_ERROR)
    |-> blen_q >= BLEN_W'(DELAY_LEN))
    else $error("frame end with short body");
`endif

endmodule
